[rtl/usb_control_endpoint_request_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// USB control endpoint request engine assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_ENDPOINT_REQUEST_ENGINE_TOP_DEFINES_SVH
`define USB_CONTROL_ENDPOINT_REQUEST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define USBCER_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define USBCER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/usbcer_pkg.sv]
// ----------------------------------------------------------------------------
// USB control endpoint request engine package
// Event and action codes, request codes, data sources and their lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package usbcer_pkg;

	typedef enum logic [1:0] {
		OP_SETUP     = 2'd0,
		OP_IN_DONE   = 2'd1,
		OP_OUT_DONE  = 2'd2,
		OP_BUS_RESET = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACT_REARM = 2'd0,
		ACT_DATA  = 2'd1,
		ACT_ZLP   = 2'd2,
		ACT_STALL = 2'd3
	} action_t;

	localparam int PACKET_BYTES_DEF = 64;

	localparam logic [7:0] RTYPE_KIND_MASK   = 8'h60;
	localparam logic [7:0] RTYPE_CLASS_MASK  = 8'h7F;
	localparam logic [7:0] RTYPE_CLASS_IFACE = 8'h21;

	localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
	localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
	localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
	localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0B;
	localparam logic [7:0] REQ_SET_LINE_CODING   = 8'h20;
	localparam logic [7:0] REQ_GET_LINE_CODING   = 8'h21;
	localparam logic [7:0] REQ_SET_CTRL_LINE     = 8'h22;

	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_STRING = 8'h03;
	localparam logic [7:0] STRING_COUNT = 8'd4;

	localparam logic [3:0] SRC_STATUS      = 4'd0;
	localparam logic [3:0] SRC_CONFIG_VAL  = 4'd1;
	localparam logic [3:0] SRC_DEVICE      = 4'd2;
	localparam logic [3:0] SRC_CONFIG      = 4'd3;
	localparam logic [3:0] SRC_STRING0     = 4'd4;
	localparam logic [3:0] SRC_STRING1     = 4'd5;
	localparam logic [3:0] SRC_STRING2     = 4'd6;
	localparam logic [3:0] SRC_STRING3     = 4'd7;
	localparam logic [3:0] SRC_LINE_CODING = 4'd8;

	localparam logic [9:0]  LINE_CODING_BYTES = 10'd7;
	localparam logic [55:0] LINE_CODING_RESET = 56'h08_0000_0001_C200;

	function automatic logic [6:0] source_length(input logic [3:0] src);
		logic [6:0] len;
		case (src)
			SRC_STATUS:      len = 7'd2;
			SRC_CONFIG_VAL:  len = 7'd1;
			SRC_DEVICE:      len = 7'd18;
			SRC_CONFIG:      len = 7'd67;
			SRC_STRING0:     len = 7'd4;
			SRC_STRING1:     len = 7'd14;
			SRC_STRING2:     len = 7'd42;
			SRC_STRING3:     len = 7'd12;
			SRC_LINE_CODING: len = 7'd7;
			default:         len = 7'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

[rtl/usb_control_endpoint_request_engine_top.sv]
// ----------------------------------------------------------------------------
// USB control endpoint request engine
// Decodes endpoint 0 events and answers each with one action for the PMA side.
// ----------------------------------------------------------------------------
// One event is taken per clock whenever busy is low; busy is high only in the
// first cycle after reset. Each event is captured in an input register, decoded
// against the endpoint state and answered from the result register, marked by a
// one-cycle done strobe. The receiver cannot stall: every result must be taken
// in the cycle it shows.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_control_endpoint_request_engine_top #(
	parameter int PACKET_BYTES = usbcer_pkg::PACKET_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  req_type,
	input  wire logic [7:0]  request,
	input  wire logic [15:0] req_value,
	input  wire logic [15:0] req_length,
	input  wire logic [9:0]  out_count,
	input  wire logic [55:0] out_data,
	output logic             done,
	output logic [1:0]       action,
	output logic [3:0]       source,
	output logic [6:0]       chunk_offset,
	output logic [6:0]       chunk_length,
	output logic             address_commit,
	output logic [6:0]       device_address,
	output logic             data_eps_enable,
	output logic             is_configured,
	output logic [55:0]      line_coding_now
);

	`include "usb_control_endpoint_request_engine_top_defines.svh"

	localparam logic [6:0] PKT = 7'(PACKET_BYTES);

	logic                 busy_q;
	logic                 valid_s1;
	usbcer_pkg::op_t      op_s1;
	logic [7:0]           req_type_s1;
	logic [7:0]           request_s1;
	logic [15:0]          req_value_s1;
	logic [15:0]          req_length_s1;
	logic [9:0]           out_count_s1;
	logic [55:0]          out_data_s1;

	logic                 configured_q;
	logic [6:0]           pending_address_q;
	logic                 address_pending_q;
	logic [6:0]           bytes_remaining_q;
	logic [3:0]           current_source_q;
	logic [6:0]           next_offset_q;
	logic [55:0]          line_coding_q;

	logic                 configured_d;
	logic [6:0]           pending_address_d;
	logic                 address_pending_d;
	logic [6:0]           bytes_remaining_d;
	logic [3:0]           current_source_d;
	logic [6:0]           next_offset_d;
	logic [55:0]          line_coding_d;

	usbcer_pkg::action_t  act_d;
	logic [3:0]           src_d;
	logic [6:0]           off_d;
	logic [6:0]           len_d;
	logic                 commit_d;
	logic [6:0]           addr_d;
	logic                 eps_d;

	logic                 send;
	logic [3:0]           send_src;
	logic [6:0]           send_total;
	logic [6:0]           send_first;
	logic [6:0]           in_n;

	logic                 done_q;
	usbcer_pkg::action_t  action_q;
	logic [3:0]           source_q;
	logic [6:0]           offset_q;
	logic [6:0]           length_q;
	logic                 commit_q;
	logic [6:0]           addr_q;
	logic                 eps_q;
	logic                 configured_out_q;
	logic [55:0]          line_coding_out_q;

	logic                 accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= usbcer_pkg::op_t'(op);
			req_type_s1   <= req_type;
			request_s1    <= request;
			req_value_s1  <= req_value;
			req_length_s1 <= req_length;
			out_count_s1  <= out_count;
			out_data_s1   <= out_data;
		end
	end

	always_comb begin
		send     = 1'b0;
		send_src = usbcer_pkg::SRC_STATUS;
		if (op_s1 == usbcer_pkg::OP_SETUP) begin
			if ((req_type_s1 & usbcer_pkg::RTYPE_KIND_MASK) == 8'h00) begin
				case (request_s1)
					usbcer_pkg::REQ_GET_STATUS: begin
						send     = 1'b1;
						send_src = usbcer_pkg::SRC_STATUS;
					end
					usbcer_pkg::REQ_GET_DESCRIPTOR: begin
						if (req_value_s1[15:8] == usbcer_pkg::DESC_DEVICE) begin
							send     = 1'b1;
							send_src = usbcer_pkg::SRC_DEVICE;
						end else if (req_value_s1[15:8] == usbcer_pkg::DESC_CONFIG) begin
							send     = 1'b1;
							send_src = usbcer_pkg::SRC_CONFIG;
						end else if (req_value_s1[15:8] == usbcer_pkg::DESC_STRING
							&& req_value_s1[7:0] < usbcer_pkg::STRING_COUNT) begin
							send     = 1'b1;
							send_src = usbcer_pkg::SRC_STRING0 | {2'b00, req_value_s1[1:0]};
						end
					end
					usbcer_pkg::REQ_GET_CONFIGURATION: begin
						send     = 1'b1;
						send_src = usbcer_pkg::SRC_CONFIG_VAL;
					end
					default: begin
						send = 1'b0;
					end
				endcase
			end else if ((req_type_s1 & usbcer_pkg::RTYPE_CLASS_MASK)
				== usbcer_pkg::RTYPE_CLASS_IFACE
				&& request_s1 == usbcer_pkg::REQ_GET_LINE_CODING) begin
				send     = 1'b1;
				send_src = usbcer_pkg::SRC_LINE_CODING;
			end
		end
	end

	always_comb begin
		send_total = usbcer_pkg::source_length(send_src);
		if (req_length_s1 < {9'd0, send_total}) begin
			send_total = req_length_s1[6:0];
		end
		send_first = (send_total > PKT) ? PKT : send_total;
		in_n       = (bytes_remaining_q > PKT) ? PKT : bytes_remaining_q;
	end

	always_comb begin
		configured_d      = configured_q;
		pending_address_d = pending_address_q;
		address_pending_d = address_pending_q;
		bytes_remaining_d = bytes_remaining_q;
		current_source_d  = current_source_q;
		next_offset_d     = next_offset_q;
		line_coding_d     = line_coding_q;
		act_d             = usbcer_pkg::ACT_REARM;
		src_d             = usbcer_pkg::SRC_STATUS;
		off_d             = 7'd0;
		len_d             = 7'd0;
		commit_d          = 1'b0;
		addr_d            = 7'd0;
		eps_d             = 1'b0;
		case (op_s1)
			usbcer_pkg::OP_SETUP: begin
				bytes_remaining_d = 7'd0;
				act_d             = usbcer_pkg::ACT_STALL;
				if (send) begin
					act_d             = usbcer_pkg::ACT_DATA;
					src_d             = send_src;
					len_d             = send_first;
					current_source_d  = send_src;
					next_offset_d     = send_first;
					bytes_remaining_d = send_total - send_first;
				end else if ((req_type_s1 & usbcer_pkg::RTYPE_KIND_MASK) == 8'h00) begin
					case (request_s1)
						usbcer_pkg::REQ_CLEAR_FEATURE,
						usbcer_pkg::REQ_SET_FEATURE,
						usbcer_pkg::REQ_SET_INTERFACE: begin
							act_d = usbcer_pkg::ACT_ZLP;
						end
						usbcer_pkg::REQ_SET_ADDRESS: begin
							pending_address_d = req_value_s1[6:0];
							address_pending_d = 1'b1;
							act_d             = usbcer_pkg::ACT_ZLP;
						end
						usbcer_pkg::REQ_SET_CONFIGURATION: begin
							configured_d = (req_value_s1 != 16'd0);
							eps_d        = (req_value_s1 != 16'd0);
							act_d        = usbcer_pkg::ACT_ZLP;
						end
						default: begin
							act_d = usbcer_pkg::ACT_STALL;
						end
					endcase
				end else if ((req_type_s1 & usbcer_pkg::RTYPE_CLASS_MASK)
					== usbcer_pkg::RTYPE_CLASS_IFACE) begin
					case (request_s1)
						usbcer_pkg::REQ_SET_LINE_CODING: begin
							act_d = usbcer_pkg::ACT_ZLP;
						end
						usbcer_pkg::REQ_SET_CTRL_LINE: begin
							if (req_value_s1[0]) begin
								configured_d = 1'b1;
							end
							act_d = usbcer_pkg::ACT_ZLP;
						end
						default: begin
							act_d = usbcer_pkg::ACT_STALL;
						end
					endcase
				end
			end
			usbcer_pkg::OP_IN_DONE: begin
				if (bytes_remaining_q != 7'd0) begin
					act_d             = usbcer_pkg::ACT_DATA;
					src_d             = current_source_q;
					off_d             = next_offset_q;
					len_d             = in_n;
					next_offset_d     = next_offset_q + in_n;
					bytes_remaining_d = bytes_remaining_q - in_n;
				end else if (address_pending_q) begin
					commit_d          = 1'b1;
					addr_d            = pending_address_q;
					address_pending_d = 1'b0;
				end
			end
			usbcer_pkg::OP_OUT_DONE: begin
				if (out_count_s1 >= usbcer_pkg::LINE_CODING_BYTES) begin
					line_coding_d = out_data_s1;
				end
			end
			usbcer_pkg::OP_BUS_RESET: begin
				configured_d      = 1'b0;
				pending_address_d = 7'd0;
				address_pending_d = 1'b0;
				bytes_remaining_d = 7'd0;
				current_source_d  = usbcer_pkg::SRC_STATUS;
				next_offset_d     = 7'd0;
			end
			default: begin
				act_d = usbcer_pkg::ACT_REARM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			configured_q      <= 1'b0;
			pending_address_q <= 7'd0;
			address_pending_q <= 1'b0;
			bytes_remaining_q <= 7'd0;
			current_source_q  <= usbcer_pkg::SRC_STATUS;
			next_offset_q     <= 7'd0;
			line_coding_q     <= usbcer_pkg::LINE_CODING_RESET;
			done_q            <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				configured_q      <= configured_d;
				pending_address_q <= pending_address_d;
				address_pending_q <= address_pending_d;
				bytes_remaining_q <= bytes_remaining_d;
				current_source_q  <= current_source_d;
				next_offset_q     <= next_offset_d;
				line_coding_q     <= line_coding_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			action_q          <= act_d;
			source_q          <= src_d;
			offset_q          <= off_d;
			length_q          <= len_d;
			commit_q          <= commit_d;
			addr_q            <= addr_d;
			eps_q             <= eps_d;
			configured_out_q  <= configured_d;
			line_coding_out_q <= line_coding_d;
		end
	end

	assign busy            = busy_q;
	assign done            = done_q;
	assign action          = action_q;
	assign source          = source_q;
	assign chunk_offset    = offset_q;
	assign chunk_length    = length_q;
	assign address_commit  = commit_q;
	assign device_address  = addr_q;
	assign data_eps_enable = eps_q;
	assign is_configured   = configured_out_q;
	assign line_coding_now = line_coding_out_q;

	`USBCER_ASSERT_NEXT(a_result_follows, valid_s1, done_q, "result strobe missing after decode")
	`USBCER_ASSERT_NOW(a_non_data_clean, done_q && action_q != usbcer_pkg::ACT_DATA,
		source_q == 4'd0 && offset_q == 7'd0 && length_q == 7'd0,
		"chunk fields set without a data action")
	`USBCER_ASSERT_NOW(a_chunk_fits, done_q, length_q <= PKT, "chunk exceeds packet size")
	`USBCER_ASSERT_NOW(a_commit_on_rearm, done_q && commit_q,
		action_q == usbcer_pkg::ACT_REARM, "address commit outside a rearm")
	`USBCER_ASSERT_NOW(a_eps_configured, done_q && eps_q, configured_out_q,
		"data endpoints enabled while not configured")

endmodule

`default_nettype wire

[tb/usb_control_endpoint_request_engine_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint 0 answer checker
// Watches accepted events, predicts the answer of each from its own copy of the
// endpoint state, and compares every strobed result field by field in order.
// ----------------------------------------------------------------------------
module usb_control_endpoint_request_engine_checker
	import usbcer_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  req_type,
	input  logic [7:0]  request,
	input  logic [15:0] req_value,
	input  logic [15:0] req_length,
	input  logic [9:0]  out_count,
	input  logic [55:0] out_data,
	input  logic        done,
	input  logic [1:0]  action,
	input  logic [3:0]  source,
	input  logic [6:0]  chunk_offset,
	input  logic [6:0]  chunk_length,
	input  logic        address_commit,
	input  logic [6:0]  device_address,
	input  logic        data_eps_enable,
	input  logic        is_configured,
	input  logic [55:0] line_coding_now,
	output int          error_count,
	output int          answers_pending
);

	typedef struct packed {
		action_t     action;
		logic [3:0]  source;
		logic [6:0]  chunk_offset;
		logic [6:0]  chunk_length;
		logic        address_commit;
		logic [6:0]  device_address;
		logic        data_eps_enable;
		logic        is_configured;
		logic [55:0] line_coding_now;
	} ep0_answer_t;

	localparam logic [8:0][6:0] SOURCE_BYTES =
		{7'd7, 7'd12, 7'd42, 7'd14, 7'd4, 7'd67, 7'd18, 7'd1, 7'd2};

	logic        configured_q;
	logic [6:0]  addr_held;
	logic        addr_held_valid;
	logic [6:0]  bytes_left;
	logic [3:0]  xfer_source;
	logic [6:0]  xfer_offset;
	logic [55:0] coding;

	ep0_answer_t answers_due[$];

	function automatic void open_transfer(input logic [3:0] src, input logic [15:0] wlen,
			inout ep0_answer_t ans);
		int total;
		int first;
		total = SOURCE_BYTES[src];
		if (wlen < total)
			total = wlen;
		first = (total > PACKET_BYTES_DEF) ? PACKET_BYTES_DEF : total;
		ans.action       = ACT_DATA;
		ans.source       = src;
		ans.chunk_offset = 7'd0;
		ans.chunk_length = 7'(first);
		xfer_source = src;
		xfer_offset = 7'(first);
		bytes_left  = 7'(total - first);
	endfunction

	function automatic ep0_answer_t predict_answer(input op_t ev, input logic [7:0] rt,
			input logic [7:0] rq, input logic [15:0] val, input logic [15:0] len,
			input logic [9:0] cnt, input logic [55:0] dat);
		ep0_answer_t ans;
		logic [6:0] n;
		ans = '0;
		ans.action = ACT_REARM;
		case (ev)
			OP_SETUP: begin
				bytes_left = '0;
				ans.action = ACT_STALL;
				if ((rt & RTYPE_KIND_MASK) == 8'h00) begin
					case (rq)
						REQ_GET_STATUS: open_transfer(SRC_STATUS, len, ans);
						REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_INTERFACE:
							ans.action = ACT_ZLP;
						REQ_SET_ADDRESS: begin
							addr_held       = val[6:0];
							addr_held_valid = 1'b1;
							ans.action      = ACT_ZLP;
						end
						REQ_GET_DESCRIPTOR: begin
							if (val[15:8] == DESC_DEVICE)
								open_transfer(SRC_DEVICE, len, ans);
							else if (val[15:8] == DESC_CONFIG)
								open_transfer(SRC_CONFIG, len, ans);
							else if (val[15:8] == DESC_STRING && val[7:0] < STRING_COUNT)
								open_transfer(SRC_STRING0 + val[1:0], len, ans);
						end
						REQ_GET_CONFIGURATION: open_transfer(SRC_CONFIG_VAL, len, ans);
						REQ_SET_CONFIGURATION: begin
							configured_q        = (val != 16'd0);
							ans.data_eps_enable = configured_q;
							ans.action          = ACT_ZLP;
						end
						default: ;
					endcase
				end else if ((rt & RTYPE_CLASS_MASK) == RTYPE_CLASS_IFACE) begin
					case (rq)
						REQ_SET_LINE_CODING: ans.action = ACT_ZLP;
						REQ_GET_LINE_CODING: open_transfer(SRC_LINE_CODING, len, ans);
						REQ_SET_CTRL_LINE: begin
							if (val[0])
								configured_q = 1'b1;
							ans.action = ACT_ZLP;
						end
						default: ;
					endcase
				end
			end
			OP_IN_DONE: begin
				if (bytes_left != 7'd0) begin
					n = (bytes_left > 7'(PACKET_BYTES_DEF)) ? 7'(PACKET_BYTES_DEF) : bytes_left;
					ans.action       = ACT_DATA;
					ans.source       = xfer_source;
					ans.chunk_offset = xfer_offset;
					ans.chunk_length = n;
					xfer_offset = xfer_offset + n;
					bytes_left  = bytes_left - n;
				end else if (addr_held_valid) begin
					ans.address_commit = 1'b1;
					ans.device_address = addr_held;
					addr_held_valid    = 1'b0;
				end
			end
			OP_OUT_DONE: begin
				if (cnt >= LINE_CODING_BYTES)
					coding = dat;
			end
			default: begin
				configured_q    = 1'b0;
				addr_held       = '0;
				addr_held_valid = 1'b0;
				bytes_left      = '0;
				xfer_source     = '0;
				xfer_offset     = '0;
			end
		endcase
		ans.is_configured   = configured_q;
		ans.line_coding_now = coding;
		return ans;
	endfunction

	task automatic check_field(input string name, input logic [55:0] want,
			input logic [55:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : watch
		ep0_answer_t want;
		if (!arst_n) begin
			configured_q    = 1'b0;
			addr_held       = '0;
			addr_held_valid = 1'b0;
			bytes_left      = '0;
			xfer_source     = '0;
			xfer_offset     = '0;
			coding          = LINE_CODING_RESET;
			answers_due.delete();
		end else begin
			if (done) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected transfer: expected none, actual action %0d",
						$time, action);
					error_count++;
				end else begin
					want = answers_due.pop_front();
					check_field("action", want.action, action);
					check_field("source", want.source, source);
					check_field("chunk_offset", want.chunk_offset, chunk_offset);
					check_field("chunk_length", want.chunk_length, chunk_length);
					check_field("address_commit", want.address_commit, address_commit);
					check_field("device_address", want.device_address, device_address);
					check_field("data_eps_enable", want.data_eps_enable, data_eps_enable);
					check_field("is_configured", want.is_configured, is_configured);
					check_field("line_coding_now", want.line_coding_now, line_coding_now);
				end
			end
			if (start && !busy)
				answers_due.push_back(predict_answer(op_t'(op), req_type, request, req_value,
					req_length, out_count, out_data));
		end
		answers_pending = answers_due.size();
	end

endmodule

[tb/usb_control_endpoint_request_engine_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint 0 request engine testbench
// Drives directed control transfers, then random request sequences under
// several sender idle rates, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module usb_control_endpoint_request_engine_top_tb;
	import usbcer_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [7:0]  req_type;
	logic [7:0]  request;
	logic [15:0] req_value;
	logic [15:0] req_length;
	logic [9:0]  out_count;
	logic [55:0] out_data;
	logic        done;
	logic [1:0]  action;
	logic [3:0]  source;
	logic [6:0]  chunk_offset;
	logic [6:0]  chunk_length;
	logic        address_commit;
	logic [6:0]  device_address;
	logic        data_eps_enable;
	logic        is_configured;
	logic [55:0] line_coding_now;

	int mismatches;
	int answers_pending;
	int idle_pct;
	int events_sent;
	int idle_plan[4] = '{81, 24, 0, 81};

	always #2 clk = ~clk;

	usb_control_endpoint_request_engine_top u_top (.*);

	usb_control_endpoint_request_engine_checker u_checker (
		.error_count(mismatches),
		.*
	);

	task automatic send_event(input op_t ev, input logic [7:0] rt, input logic [7:0] rq,
			input logic [15:0] val, input logic [15:0] len, input logic [9:0] cnt,
			input logic [55:0] dat);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		op         <= ev;
		req_type   <= rt;
		request    <= rq;
		req_value  <= val;
		req_length <= len;
		out_count  <= cnt;
		out_data   <= dat;
		do
			@(posedge clk);
		while (busy);
		events_sent++;
	endtask

	task automatic setup_packet(input logic [7:0] rt, input logic [7:0] rq,
			input logic [15:0] val, input logic [15:0] len);
		send_event(OP_SETUP, rt, rq, val, len, 10'($urandom()),
			56'({$urandom(), $urandom()}));
	endtask

	task automatic in_done();
		send_event(OP_IN_DONE, 8'($urandom()), 8'($urandom()), 16'($urandom()),
			16'($urandom()), 10'($urandom()), 56'({$urandom(), $urandom()}));
	endtask

	task automatic out_done(input logic [9:0] cnt, input logic [55:0] dat);
		send_event(OP_OUT_DONE, 8'($urandom()), 8'($urandom()), 16'($urandom()),
			16'($urandom()), cnt, dat);
	endtask

	task automatic bus_reset();
		send_event(OP_BUS_RESET, 8'($urandom()), 8'($urandom()), 16'($urandom()),
			16'($urandom()), 10'($urandom()), 56'({$urandom(), $urandom()}));
	endtask

	function automatic logic [7:0] std_rtype();
		return 8'($urandom()) & 8'h9F;
	endfunction

	function automatic logic [7:0] class_rtype();
		return {1'($urandom_range(1)), 7'h21};
	endfunction

	function automatic logic [15:0] host_length();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4: return 16'($urandom_range(1, 80));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic random_exchange();
		logic [7:0] dtype;
		logic [7:0] idx;
		case ($urandom_range(15))
			0, 1, 2, 3, 4, 5: begin
				case ($urandom_range(3))
					0: dtype = DESC_DEVICE;
					1: dtype = DESC_CONFIG;
					2: dtype = DESC_STRING;
					default: dtype = 8'($urandom());
				endcase
				idx = ($urandom_range(7) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
				setup_packet(std_rtype(), REQ_GET_DESCRIPTOR, {dtype, idx}, host_length());
				repeat ($urandom_range(3)) in_done();
			end
			6: begin
				setup_packet(std_rtype(),
					$urandom_range(1) ? REQ_GET_STATUS : REQ_GET_CONFIGURATION,
					16'($urandom()), host_length());
				repeat ($urandom_range(2)) in_done();
			end
			7: begin
				setup_packet(std_rtype(), REQ_SET_ADDRESS, 16'($urandom()), host_length());
				if ($urandom_range(3) != 0)
					in_done();
			end
			8: setup_packet(std_rtype(), REQ_SET_CONFIGURATION,
				$urandom_range(1) ? 16'($urandom_range(1)) : 16'($urandom()), host_length());
			9: begin
				case ($urandom_range(2))
					0: setup_packet(std_rtype(), REQ_CLEAR_FEATURE, 16'($urandom()),
						host_length());
					1: setup_packet(std_rtype(), REQ_SET_FEATURE, 16'($urandom()),
						host_length());
					default: setup_packet(std_rtype(), REQ_SET_INTERFACE, 16'($urandom()),
						host_length());
				endcase
			end
			10: begin
				setup_packet(class_rtype(), REQ_SET_LINE_CODING, 16'($urandom()), 16'd7);
				out_done(($urandom_range(4) == 0) ? 10'($urandom_range(6))
					: 10'($urandom_range(7, 1023)), 56'({$urandom(), $urandom()}));
			end
			11: begin
				setup_packet(class_rtype(), REQ_GET_LINE_CODING, 16'($urandom()),
					host_length());
				repeat ($urandom_range(2)) in_done();
			end
			12: setup_packet(class_rtype(), REQ_SET_CTRL_LINE, 16'($urandom()),
				host_length());
			13: bus_reset();
			14: send_event(op_t'($urandom_range(3)), 8'($urandom()), 8'($urandom()),
				16'($urandom()), 16'($urandom()), 10'($urandom()),
				56'({$urandom(), $urandom()}));
			default: begin
				case ($urandom_range(2))
					0: in_done();
					1: out_done(10'($urandom()), 56'({$urandom(), $urandom()}));
					default: setup_packet(8'($urandom()), 8'($urandom()),
						16'($urandom()), host_length());
				endcase
			end
		endcase
	endtask

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int goal;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		op         <= OP_SETUP;
		req_type   <= '0;
		request    <= '0;
		req_value  <= '0;
		req_length <= '0;
		out_count  <= '0;
		out_data   <= '0;
		idle_pct    = 0;
		events_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		setup_packet(8'h80, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'hFFFF);
		setup_packet(8'h80, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'hFFFF);
		in_done();
		in_done();
		setup_packet(8'h80, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'd0);
		setup_packet(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h03}, 16'd5);
		setup_packet(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h04}, 16'hFFFF);
		setup_packet(8'h80, REQ_GET_DESCRIPTOR, 16'hFF00, 16'hFFFF);
		setup_packet(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'd0);
		in_done();
		setup_packet(8'h80, REQ_GET_STATUS, 16'd0, 16'hFFFF);
		setup_packet(8'h80, REQ_GET_CONFIGURATION, 16'd0, 16'hFFFF);
		setup_packet(8'h00, REQ_SET_CONFIGURATION, 16'hFFFF, 16'd0);
		setup_packet(8'h00, REQ_CLEAR_FEATURE, 16'd0, 16'd0);
		setup_packet(8'h00, REQ_SET_FEATURE, 16'd0, 16'd0);
		setup_packet(8'h01, REQ_SET_INTERFACE, 16'd0, 16'd0);
		setup_packet(8'h21, REQ_SET_LINE_CODING, 16'd0, 16'd7);
		out_done(10'd1023, 56'hFF_FFFF_FFFF_FFFF);
		out_done(10'd6, 56'd0);
		setup_packet(8'hA1, REQ_GET_LINE_CODING, 16'd0, 16'hFFFF);
		setup_packet(8'h21, REQ_SET_CTRL_LINE, 16'd1, 16'd0);
		setup_packet(8'hA1, 8'hFF, 16'd0, 16'd0);
		setup_packet(8'h40, REQ_GET_STATUS, 16'd0, 16'd2);
		setup_packet(8'hFF, REQ_GET_LINE_CODING, 16'd0, 16'd7);
		setup_packet(8'h80, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'hFFFF);
		setup_packet(8'h00, REQ_SET_ADDRESS, 16'h0055, 16'd0);
		bus_reset();
		in_done();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_plan[p];
			goal = events_sent + 256;
			while (events_sent < goal)
				random_exchange();
		end

		start <= 1'b0;
		@(posedge clk);
		while (answers_pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
